// File: design/assert_macros.svh
// assertion macros used by user_id_scrambler_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/uis_pkg.sv
// types, constants and bit-mixing functions of the user id scrambler
`default_nettype none

package uis_pkg;

    localparam int unsigned ID_W            = 53;
    localparam int unsigned REM_W           = 10;
    localparam int unsigned HI_W            = ID_W - REM_W;
    localparam int unsigned DIV_STEPS       = HI_W;
    localparam int unsigned STEPS_PER_STAGE = 8;
    localparam int unsigned NUM_DIV_STAGES  =
        (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int unsigned MIX_BYTES       = 6;

    localparam logic [ID_W-1:0] POLY     = 53'h0000000000635;
    localparam logic [ID_W-1:0] MIX_XOR_A = 53'h0B3B3B3B3B3B3;
    localparam logic [ID_W-1:0] MIX_XOR_B = 53'h05E5E5E5E5E5E;
    localparam logic [ID_W:0]   ID_LIMIT  = 54'd9999999999999999;

    typedef struct packed {
        logic [HI_W-1:0] hi;
        logic [ID_W-1:0] rem;
    } t_div_data;

    function automatic logic [3:0] nib_sub(input logic [3:0] n);
        logic [3:0] s;
        unique case (n)
            4'h0: s = 4'h4;
            4'h1: s = 4'hB;
            4'h2: s = 4'h7;
            4'h3: s = 4'h9;
            4'h4: s = 4'hF;
            4'h5: s = 4'h1;
            4'h6: s = 4'hD;
            4'h7: s = 4'h3;
            4'h8: s = 4'hC;
            4'h9: s = 4'h2;
            4'hA: s = 4'h6;
            4'hB: s = 4'hE;
            4'hC: s = 4'h8;
            4'hD: s = 4'h0;
            4'hE: s = 4'hA;
            default: s = 4'h5;
        endcase
        return s;
    endfunction

    // destination byte of each of the low six bytes
    function automatic int unsigned byte_dest(input int unsigned b);
        int unsigned d;
        unique case (b)
            0: d = 1;
            1: d = 5;
            2: d = 0;
            3: d = 4;
            4: d = 2;
            5: d = 3;
            default: d = b;
        endcase
        return d;
    endfunction

    // a slice of the long division over gf(2), one quotient bit per step
    function automatic logic [ID_W-1:0] div_steps(input logic [ID_W-1:0] rem_in,
                                                  input int unsigned first,
                                                  input int unsigned count);
        logic [ID_W-1:0] r;
        int unsigned     k;
        r = rem_in;
        for (int unsigned i = 0; i < STEPS_PER_STAGE; i++) begin
            k = first + i;
            if (i < count && k < DIV_STEPS) begin
                if (r[ID_W-1-k]) begin
                    r = r ^ (POLY << (DIV_STEPS - 1 - k));
                end
            end
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] mix(input t_div_data d);
        logic [ID_W-1:0] w;
        logic [ID_W-1:0] rot;
        logic [ID_W-1:0] sub;
        logic [ID_W-1:0] perm;
        w   = {d.hi, d.rem[REM_W-1:0]} ^ MIX_XOR_A;
        rot = {w[REM_W-1:0], w[ID_W-1:REM_W]};
        sub = rot;
        for (int unsigned j = 0; j < 2 * MIX_BYTES; j++) begin
            sub[4*j +: 4] = nib_sub(rot[4*j +: 4]);
        end
        perm = sub;
        for (int unsigned i = 0; i < MIX_BYTES; i++) begin
            perm[8*byte_dest(i) +: 8] = sub[8*i +: 8];
        end
        return {perm[ID_W-2:0], perm[ID_W-1]} ^ MIX_XOR_B;
    endfunction

endpackage

`default_nettype wire

// File: design/uis_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none

interface uis_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] hw_id;
    logic [7:0]  gen_counter;
    logic [2:0]  model_code;
    logic [2:0]  region_code;

    modport source (output valid, hw_id, gen_counter, model_code, region_code,
                    input ready);
    modport sink   (input valid, hw_id, gen_counter, model_code, region_code,
                    output ready);
endinterface

interface uis_out_if;
    logic        valid;
    logic        ready;
    logic [52:0] scrambled_id;
    logic        status;

    modport source (output valid, scrambled_id, status, input ready);
    modport sink   (input valid, scrambled_id, status, output ready);
endinterface

`default_nettype wire

// File: design/user_id_scrambler_core.sv
// user id scrambler top level: division slices, mixing stage, result register
// stages: the accepting edge loads the first of 6 division slices; the other
// slices, the mixing stage and the result register follow in that order
// throughput: one item per cycle unless the output stalls; each stage has its
// own valid bit, so bubbles close up and items fill in behind a stalled result
// reset: synchronous active low, clears every stage valid bit
`default_nettype none

`include "assert_macros.svh"

module user_id_scrambler_core
    import uis_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    uis_in_if.sink    i_in,
    uis_out_if.source o_out
);

    logic      s_valid [0:NUM_DIV_STAGES];
    logic      s_ready [0:NUM_DIV_STAGES];
    t_div_data s_data  [0:NUM_DIV_STAGES];
    logic [ID_W-1:0] base;

    logic            mix_valid;
    logic            mix_ready;
    logic [ID_W-1:0] mix_word;

    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_status;
    logic            out_ready;

    assign base = ({50'd0, i_in.region_code} << 50) |
                  ({50'd0, i_in.model_code} << 47) |
                  ({21'd0, i_in.hw_id} << 15) |
                  ({45'd0, i_in.gen_counter} << 10);

    assign s_valid[0]    = i_in.valid;
    assign i_in.ready    = s_ready[0];
    assign s_data[0].hi  = base[ID_W-1:REM_W];
    assign s_data[0].rem = base;

    for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
        localparam int unsigned FIRST = g * STEPS_PER_STAGE;
        localparam int unsigned COUNT =
            (DIV_STEPS - FIRST < STEPS_PER_STAGE) ? DIV_STEPS - FIRST : STEPS_PER_STAGE;

        uis_div_stage #(
            .P_FIRST(FIRST),
            .P_COUNT(COUNT)
        ) u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(s_valid[g]),
            .o_ready(s_ready[g]),
            .i_data (s_data[g]),
            .o_valid(s_valid[g+1]),
            .i_ready(s_ready[g+1]),
            .o_data (s_data[g+1])
        );
    end

    uis_mix_stage u_mix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_valid[NUM_DIV_STAGES]),
        .o_ready(s_ready[NUM_DIV_STAGES]),
        .i_data (s_data[NUM_DIV_STAGES]),
        .o_valid(mix_valid),
        .i_ready(mix_ready),
        .o_word (mix_word)
    );

    // result register with the sixteen-digit range check
    assign out_ready = !r_out_valid || o_out.ready;
    assign mix_ready = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= mix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && mix_valid) begin
            r_out_id     <= mix_word;
            r_out_status <= ({1'b0, mix_word} > ID_LIMIT);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scrambled_id = r_out_id;
    assign o_out.status       = r_out_status;

    `ASSERT_NEXT(a_mix_held, i_clk, i_rst_n, mix_valid && !mix_ready,
                 mix_valid && $stable(mix_word), "mixed item lost while stalled")
    `ASSERT_NEXT(a_mix_moves, i_clk, i_rst_n, mix_valid && mix_ready,
                 r_out_valid && (r_out_id == $past(mix_word)), "mixed item not passed on")
    `ASSERT_SAME(a_bubble_in, i_clk, i_rst_n, !s_valid[1], i_in.ready,
                 "input refused with empty first stage")
    `ASSERT_SAME(a_out_free, i_clk, i_rst_n, !r_out_valid, mix_ready,
                 "mixing stage stalled behind empty result register")

endmodule

`default_nettype wire

// File: design/uis_div_stage.sv
// one registered slice of the polynomial division
`default_nettype none

module uis_div_stage
    import uis_pkg::*;
#(
    parameter int unsigned P_FIRST = 0,
    parameter int unsigned P_COUNT = STEPS_PER_STAGE
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_data i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_data      o_data
);

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data     = i_data;
        n_data.rem = div_steps(i_data.rem, P_FIRST, P_COUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: design/uis_mix_stage.sv
// registered stage for xor, rotations, nibble substitution and byte shuffle
`default_nettype none

module uis_mix_stage
    import uis_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_data i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic [ID_W-1:0] o_word
);

    logic            r_valid;
    logic [ID_W-1:0] r_word;
    logic [ID_W-1:0] n_word;

    assign o_ready = !r_valid || i_ready;
    assign n_word  = mix(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// testbench for user_id_scrambler_core: random and directed ids checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] dev;
        logic [7:0]  ctr;
        logic [2:0]  model;
        logic [2:0]  region;
        logic        drain_first;
    } t_id_request;

    typedef struct packed {
        logic [52:0] scrambled;
        logic        status;
    } t_id_result;

    localparam logic [52:0] GEN_POLY    = 53'h635;
    localparam logic [52:0] SCR_XOR_IN  = 53'h0B3B3B3B3B3B3;
    localparam logic [52:0] SCR_XOR_OUT = 53'h05E5E5E5E5E5E;
    localparam logic [63:0] ID_CEILING  = 64'd9999999999999999;
    localparam logic [3:0]  NIB_TABLE [16] = '{
        4'h4, 4'hB, 4'h7, 4'h9, 4'hF, 4'h1, 4'hD, 4'h3,
        4'hC, 4'h2, 4'h6, 4'hE, 4'h8, 4'h0, 4'hA, 4'h5
    };
    localparam int unsigned BYTE_TO [6] = '{1, 5, 0, 4, 2, 3};
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned LONG_HOLD    = 300;

    logic i_clk;
    logic i_rst_n;

    uis_in_if  in_if ();
    uis_out_if out_if ();

    user_id_scrambler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_id_request pending_items[$];
    t_id_result  expected_ids[$];
    t_id_request cur_item;
    bit          offering;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned n_accepted;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned n_errors;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_id_result predict_user_id(input t_id_request r);
        logic [52:0] word;
        logic [52:0] divd;
        logic [52:0] mixed;
        logic [52:0] subbed;
        logic [52:0] placed;
        t_id_result  res;
        word = {r.region, r.model, 47'b0} | (53'(r.dev) << 15) | (53'(r.ctr) << 10);
        // gf(2) long division down to a 10-bit remainder
        divd = word;
        for (int k = 0; k <= 42; k++) begin
            if (divd[52-k]) begin
                divd = divd ^ (GEN_POLY << (42 - k));
            end
        end
        mixed = (word | {43'b0, divd[9:0]}) ^ SCR_XOR_IN;
        mixed = {mixed[9:0], mixed[52:10]};
        subbed = mixed;
        for (int n = 0; n < 12; n++) begin
            subbed[4*n +: 4] = NIB_TABLE[mixed[4*n +: 4]];
        end
        // bytes 6 and up stay where they are
        placed = subbed;
        for (int b = 0; b < 6; b++) begin
            placed[8*BYTE_TO[b] +: 8] = subbed[8*b +: 8];
        end
        res.scrambled = {placed[51:0], placed[52]} ^ SCR_XOR_OUT;
        res.status    = (64'(res.scrambled) > ID_CEILING);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        n_errors++;
    endtask

    // idle-free stretches on both sides every few hundred items
    function automatic bit quiet_phase();
        return ((n_accepted / 150) % 4) == 3;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            offering     = 1'b0;
            gap_left     = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_ids.push_back(predict_user_id(cur_item));
                n_accepted <= n_accepted + 1;
                offering    = 1'b0;
                gap_left    = quiet_phase() ? 0 : $urandom_range(0, 5);
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain_first && expected_ids.size() > 0)) begin
                    cur_item = pending_items.pop_front();
                    offering = 1'b1;
                    in_if.hw_id       <= cur_item.dev;
                    in_if.gen_counter <= cur_item.ctr;
                    in_if.model_code  <= cur_item.model;
                    in_if.region_code <= cur_item.region;
                end
            end
            in_if.valid <= offering;
        end
    end

    // one long receiver hold-off so the pipeline fills and backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= 600) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_id_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_ids.size() == 0) begin
                    report_mismatch("unexpected result", 64'(out_if.scrambled_id), 64'd0);
                end else begin
                    want = expected_ids.pop_front();
                    if (out_if.scrambled_id !== want.scrambled) begin
                        report_mismatch("scrambled_id", 64'(out_if.scrambled_id),
                                        64'(want.scrambled));
                    end
                    if (out_if.status !== want.status) begin
                        report_mismatch("status", 64'(out_if.status), 64'(want.status));
                    end
                end
                stall_left = quiet_phase() ? 0 : $urandom_range(0, 5);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    function automatic t_id_request make_item(input logic [31:0] dev, input logic [7:0] ctr,
                                              input logic [2:0] model, input logic [2:0] region);
        t_id_request r;
        r.dev         = dev;
        r.ctr         = ctr;
        r.model       = model;
        r.region      = region;
        r.drain_first = 1'b0;
        return r;
    endfunction

    initial begin
        t_id_request r;
        n_errors   = 0;
        n_accepted = 0;
        i_rst_n    = 1'b0;
        in_if.valid       = 1'b0;
        in_if.hw_id       = '0;
        in_if.gen_counter = '0;
        in_if.model_code  = '0;
        in_if.region_code = '0;
        out_if.ready      = 1'b0;

        // field extremes and alternating patterns
        pending_items.push_back(make_item(32'h0, 8'h00, 3'd0, 3'd0));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 8'hFF, 3'd7, 3'd7));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 8'h00, 3'd0, 3'd0));
        pending_items.push_back(make_item(32'h0, 8'hFF, 3'd0, 3'd0));
        pending_items.push_back(make_item(32'h0, 8'h00, 3'd7, 3'd0));
        pending_items.push_back(make_item(32'h0, 8'h00, 3'd0, 3'd7));
        pending_items.push_back(make_item(32'hAAAA_AAAA, 8'hAA, 3'd5, 3'd2));
        pending_items.push_back(make_item(32'h5555_5555, 8'h55, 3'd2, 3'd5));
        pending_items.push_back(make_item(32'h8000_0000, 8'h80, 3'd4, 3'd4));
        pending_items.push_back(make_item(32'h0000_0001, 8'h01, 3'd1, 3'd1));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 8'hFF, 3'd7, 3'd6));
        pending_items.push_back(make_item(32'h0000_0007, 8'hE0, 3'd3, 3'd7));
        pending_items.push_back(make_item(32'hDEAD_BEEF, 8'h3C, 3'd6, 3'd3));
        pending_items.push_back(make_item(32'hF0F0_F0F0, 8'h0F, 3'd7, 3'd0));

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            r = make_item($urandom, 8'($urandom), 3'($urandom), 3'($urandom));
            // sender waits for the pipeline to empty at these points
            r.drain_first = (i == 0) || (i == 1200);
            pending_items.push_back(r);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !offering);
        wait (expected_ids.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && expected_ids.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
